@@ hw/rtl/mfv_pkg.sv @@
// Package with the phase codes, status codes, register indexes and type classes of the frame validator.
`timescale 1ns / 1ps

package mfv_pkg;

   localparam int unsigned MagicBytes = 4;
   localparam int unsigned LenOffset  = 6;
   localparam int unsigned HdrBytes   = 14;

   localparam int unsigned IdxWidth   = 33;
   localparam int unsigned PhaseWidth = 4;

   localparam logic [PhaseWidth-1:0] PH_IDLE  = 4'd0;
   localparam logic [PhaseWidth-1:0] PH_PORT  = 4'd1;
   localparam logic [PhaseWidth-1:0] PH_S1LEN = 4'd2;
   localparam logic [PhaseWidth-1:0] PH_S1DAT = 4'd3;
   localparam logic [PhaseWidth-1:0] PH_S2LEN = 4'd4;
   localparam logic [PhaseWidth-1:0] PH_S2DAT = 4'd5;
   localparam logic [PhaseWidth-1:0] PH_COUNT = 4'd6;
   localparam logic [PhaseWidth-1:0] PH_SLEN  = 4'd7;
   localparam logic [PhaseWidth-1:0] PH_SDAT  = 4'd8;
   localparam logic [PhaseWidth-1:0] PH_SIZE  = 4'd9;
   localparam logic [PhaseWidth-1:0] PH_DONE  = 4'd10;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_SHORT     = 3'd1;
   localparam logic [2:0] ST_MAGIC     = 3'd2;
   localparam logic [2:0] ST_VERSION   = 3'd3;
   localparam logic [2:0] ST_LENGTH    = 3'd4;
   localparam logic [2:0] ST_MALFORMED = 3'd5;

   localparam logic [2:0] REG_MAGIC     = 3'd0;
   localparam logic [2:0] REG_VERSION   = 3'd1;
   localparam logic [2:0] REG_HELLO     = 3'd2;
   localparam logic [2:0] REG_HELLO_ACK = 3'd3;
   localparam logic [2:0] REG_FILE_LIST = 3'd4;
   localparam logic [2:0] REG_FILE_INFO = 3'd5;

   localparam logic [31:0] MagicReset     = 32'd0;
   localparam logic [7:0]  VersionReset   = 8'd0;
   localparam logic [7:0]  HelloReset     = 8'd0;
   localparam logic [7:0]  HelloAckReset  = 8'd1;
   localparam logic [7:0]  FileListReset  = 8'd2;
   localparam logic [7:0]  FileInfoReset  = 8'd3;

   typedef enum logic [1:0] {
      CL_HELLO = 2'd0,
      CL_LIST  = 2'd1,
      CL_INFO  = 2'd2,
      CL_OTHER = 2'd3
   } msg_class_type;

   // Hello and hello-ack both map to the hello class, which wins over file list, then file info.
   function automatic msg_class_type class_of(
      input logic [7:0] msg_type,
      input logic [7:0] hello,
      input logic [7:0] hello_ack,
      input logic [7:0] file_list,
      input logic [7:0] file_info
   );
      msg_class_type cls;
      if (msg_type == hello || msg_type == hello_ack) begin
         cls = CL_HELLO;
      end else if (msg_type == file_list) begin
         cls = CL_LIST;
      end else if (msg_type == file_info) begin
         cls = CL_INFO;
      end else begin
         cls = CL_OTHER;
      end
      return cls;
   endfunction

endpackage

@@ hw/rtl/message_frame_validator_unit.sv @@
// Streaming frame validator: header and body checks on one byte per transfer, one result per frame.
//
// The unit takes one frame byte per cycle and stalls no byte of a frame but its last: each byte only
// updates counters, a 64-bit field shifter and the header registers, and the last byte of a frame
// loads the result register in the same cycle. A result waits in that register until it is
// transferred; further bytes of the next frame are still taken meanwhile, and only a last byte
// stalls while the previous result has not yet left. Configuration registers should be written
// between frames.
`timescale 1ns / 1ps

module message_frame_validator_unit
   import mfv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_msg_type,
   output logic [31:0] rsp_seq_number,
   output logic [31:0] rsp_body_length,
   output logic [15:0] rsp_peer_port,
   output logic [31:0] rsp_entry_count,
   output logic [63:0] rsp_file_size
);

   logic [31:0] magic_word_ff;
   logic [7:0]  version_code_ff;
   logic [7:0]  hello_code_ff;
   logic [7:0]  hello_ack_code_ff;
   logic [7:0]  file_list_code_ff;
   logic [7:0]  file_info_code_ff;

   logic [IdxWidth-1:0]   byte_index_ff,       byte_index_in;
   logic                  magic_ok_ff,         magic_ok_in;
   logic                  version_ok_ff,       version_ok_in;
   logic [7:0]            header_type_ff,      header_type_in;
   logic [31:0]           header_length_ff,    header_length_in;
   logic [31:0]           header_seq_ff,       header_seq_in;
   logic [PhaseWidth-1:0] body_phase_ff,       body_phase_in;
   logic [63:0]           field_shift_ff,      field_shift_in;
   logic [15:0]           field_bytes_left_ff, field_bytes_left_in;
   logic [31:0]           entries_left_ff,     entries_left_in;
   logic                  body_overrun_ff,     body_overrun_in;
   logic [15:0]           cap_port_ff,         cap_port_in;
   logic [31:0]           cap_count_ff,        cap_count_in;
   logic [63:0]           cap_size_ff,         cap_size_in;

   logic        rsp_valid_ff,       rsp_valid_in;
   logic [2:0]  rsp_status_ff,      rsp_status_in;
   logic [7:0]  rsp_msg_type_ff,    rsp_msg_type_in;
   logic [31:0] rsp_seq_number_ff,  rsp_seq_number_in;
   logic [31:0] rsp_body_length_ff, rsp_body_length_in;
   logic [15:0] rsp_peer_port_ff,   rsp_peer_port_in;
   logic [31:0] rsp_entry_count_ff, rsp_entry_count_in;
   logic [63:0] rsp_file_size_ff,   rsp_file_size_in;

   logic                  req_fire;
   logic                  rsp_fire;
   logic [7:0]            magic_byte;
   logic [PhaseWidth-1:0] phase_w;
   logic [15:0]           left_w;
   logic [15:0]           left_dec;
   logic [63:0]           shift_next;
   logic [31:0]           entries_dec;
   logic [IdxWidth-1:0]   length_end;
   logic [2:0]            status_w;
   msg_class_type         cls_body;
   msg_class_type         cls_end;

   assign req_stall = rsp_valid_ff && rsp_stall && req_last_byte;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_word_ff     <= MagicReset;
         version_code_ff   <= VersionReset;
         hello_code_ff     <= HelloReset;
         hello_ack_code_ff <= HelloAckReset;
         file_list_code_ff <= FileListReset;
         file_info_code_ff <= FileInfoReset;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MAGIC:     magic_word_ff     <= csr_data;
            REG_VERSION:   version_code_ff   <= csr_data[7:0];
            REG_HELLO:     hello_code_ff     <= csr_data[7:0];
            REG_HELLO_ACK: hello_ack_code_ff <= csr_data[7:0];
            REG_FILE_LIST: file_list_code_ff <= csr_data[7:0];
            REG_FILE_INFO: file_info_code_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (byte_index_ff[1:0])
         2'd0:    magic_byte = magic_word_ff[31:24];
         2'd1:    magic_byte = magic_word_ff[23:16];
         2'd2:    magic_byte = magic_word_ff[15:8];
         default: magic_byte = magic_word_ff[7:0];
      endcase
   end

   assign cls_body = class_of(header_type_ff, hello_code_ff, hello_ack_code_ff,
                              file_list_code_ff, file_info_code_ff);
   assign cls_end  = class_of(header_type_in, hello_code_ff, hello_ack_code_ff,
                              file_list_code_ff, file_info_code_ff);

   // The first body byte opens the first field of the body for the message class.
   always_comb begin
      phase_w = body_phase_ff;
      left_w  = field_bytes_left_ff;
      if (body_phase_ff == PH_IDLE) begin
         unique case (cls_body)
            CL_HELLO: begin
               phase_w = PH_PORT;
               left_w  = 16'd2;
            end
            CL_LIST: begin
               phase_w = PH_COUNT;
               left_w  = 16'd4;
            end
            default: begin
               phase_w = PH_SLEN;
               left_w  = 16'd2;
            end
         endcase
      end
   end

   assign shift_next  = (body_phase_ff == PH_IDLE) ? {56'd0, req_data_byte}
                                                   : {field_shift_ff[55:0], req_data_byte};
   assign left_dec    = left_w - 16'(left_w != 16'd0);
   assign entries_dec = entries_left_ff - 32'(entries_left_ff != 32'd0);

   always_comb begin
      byte_index_in       = byte_index_ff;
      magic_ok_in         = magic_ok_ff;
      version_ok_in       = version_ok_ff;
      header_type_in      = header_type_ff;
      header_length_in    = header_length_ff;
      header_seq_in       = header_seq_ff;
      body_phase_in       = body_phase_ff;
      field_shift_in      = field_shift_ff;
      field_bytes_left_in = field_bytes_left_ff;
      entries_left_in     = entries_left_ff;
      body_overrun_in     = body_overrun_ff;
      cap_port_in         = cap_port_ff;
      cap_count_in        = cap_count_ff;
      cap_size_in         = cap_size_ff;

      if (req_fire) begin
         if (byte_index_ff < IdxWidth'(MagicBytes)) begin
            magic_ok_in = magic_ok_ff && (magic_byte == req_data_byte);
         end else if (byte_index_ff == IdxWidth'(MagicBytes)) begin
            version_ok_in = version_ok_ff && (req_data_byte == version_code_ff);
         end else if (byte_index_ff == IdxWidth'(MagicBytes + 1)) begin
            header_type_in = req_data_byte;
         end else if (byte_index_ff < IdxWidth'(LenOffset + 4)) begin
            header_length_in = {header_length_ff[23:0], req_data_byte};
         end else if (byte_index_ff < IdxWidth'(HdrBytes)) begin
            header_seq_in = {header_seq_ff[23:0], req_data_byte};
         end else begin
            unique case (phase_w)
               PH_PORT, PH_S1LEN, PH_S2LEN, PH_COUNT, PH_SLEN, PH_SIZE: begin
                  body_phase_in       = phase_w;
                  field_shift_in      = shift_next;
                  field_bytes_left_in = left_dec;
                  if (left_dec == 16'd0) begin
                     field_shift_in = 64'd0;
                     unique case (phase_w)
                        PH_PORT: begin
                           cap_port_in         = shift_next[15:0];
                           body_phase_in       = PH_S1LEN;
                           field_bytes_left_in = 16'd2;
                        end
                        PH_S1LEN, PH_S2LEN, PH_SLEN: begin
                           if (shift_next[15:0] != 16'd0) begin
                              field_shift_in      = shift_next;
                              field_bytes_left_in = shift_next[15:0];
                              body_phase_in       = phase_w + 4'd1;
                           end else if (phase_w == PH_S1LEN) begin
                              body_phase_in       = PH_S2LEN;
                              field_bytes_left_in = 16'd2;
                           end else if (phase_w == PH_S2LEN) begin
                              field_shift_in = shift_next;
                              body_phase_in  = PH_DONE;
                           end else if (cls_body == CL_LIST || cls_body == CL_INFO) begin
                              body_phase_in       = PH_SIZE;
                              field_bytes_left_in = 16'd8;
                           end else begin
                              field_shift_in = shift_next;
                              body_phase_in  = PH_DONE;
                           end
                        end
                        PH_COUNT: begin
                           cap_count_in    = shift_next[31:0];
                           entries_left_in = shift_next[31:0];
                           if (shift_next[31:0] == 32'd0) begin
                              field_shift_in = shift_next;
                              body_phase_in  = PH_DONE;
                           end else begin
                              body_phase_in       = PH_SLEN;
                              field_bytes_left_in = 16'd2;
                           end
                        end
                        default: begin
                           cap_size_in = shift_next;
                           if (cls_body == CL_LIST && entries_dec != 32'd0) begin
                              entries_left_in     = entries_dec;
                              body_phase_in       = PH_SLEN;
                              field_bytes_left_in = 16'd2;
                           end else begin
                              if (cls_body == CL_LIST) begin
                                 entries_left_in = entries_dec;
                              end
                              field_shift_in = shift_next;
                              body_phase_in  = PH_DONE;
                           end
                        end
                     endcase
                  end
               end
               PH_S1DAT, PH_S2DAT, PH_SDAT: begin
                  field_bytes_left_in = left_dec;
                  if (left_dec == 16'd0) begin
                     if (phase_w == PH_S1DAT) begin
                        body_phase_in       = PH_S2LEN;
                        field_bytes_left_in = 16'd2;
                        field_shift_in      = 64'd0;
                     end else if (phase_w == PH_S2DAT) begin
                        body_phase_in = PH_DONE;
                     end else if (cls_body == CL_LIST || cls_body == CL_INFO) begin
                        body_phase_in       = PH_SIZE;
                        field_bytes_left_in = 16'd8;
                        field_shift_in      = 64'd0;
                     end else begin
                        body_phase_in = PH_DONE;
                     end
                  end
               end
               default: begin
                  body_overrun_in = 1'b1;
               end
            endcase
         end

         if (byte_index_ff != {IdxWidth{1'b1}}) begin
            byte_index_in = byte_index_ff + IdxWidth'(1);
         end
      end
   end

   // The length check expects the frame's last byte index to equal 13 plus the declared body length.
   assign length_end = IdxWidth'(header_length_in) + IdxWidth'(HdrBytes - 1);

   always_comb begin
      if (byte_index_ff < IdxWidth'(HdrBytes - 1)) begin
         status_w = ST_SHORT;
      end else if (!magic_ok_in) begin
         status_w = ST_MAGIC;
      end else if (!version_ok_in) begin
         status_w = ST_VERSION;
      end else if (byte_index_ff != length_end) begin
         status_w = ST_LENGTH;
      end else if (body_phase_in != PH_DONE || body_overrun_in) begin
         status_w = ST_MALFORMED;
      end else begin
         status_w = ST_OK;
      end
   end

   always_comb begin
      rsp_valid_in       = rsp_valid_ff && !rsp_fire;
      rsp_status_in      = rsp_status_ff;
      rsp_msg_type_in    = rsp_msg_type_ff;
      rsp_seq_number_in  = rsp_seq_number_ff;
      rsp_body_length_in = rsp_body_length_ff;
      rsp_peer_port_in   = rsp_peer_port_ff;
      rsp_entry_count_in = rsp_entry_count_ff;
      rsp_file_size_in   = rsp_file_size_ff;
      if (req_fire && req_last_byte) begin
         rsp_valid_in       = 1'b1;
         rsp_status_in      = status_w;
         rsp_msg_type_in    = (status_w != ST_SHORT) ? header_type_in : 8'd0;
         rsp_seq_number_in  = (status_w != ST_SHORT) ? header_seq_in : 32'd0;
         rsp_body_length_in = (status_w != ST_SHORT) ? header_length_in : 32'd0;
         rsp_peer_port_in   = (status_w == ST_OK && cls_end == CL_HELLO) ? cap_port_in : 16'd0;
         rsp_entry_count_in = (status_w == ST_OK && cls_end == CL_LIST) ? cap_count_in : 32'd0;
         rsp_file_size_in   = (status_w == ST_OK && (cls_end == CL_LIST || cls_end == CL_INFO))
                              ? cap_size_in : 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (req_fire && req_last_byte)) begin
         byte_index_ff       <= '0;
         magic_ok_ff         <= 1'b1;
         version_ok_ff       <= 1'b1;
         header_type_ff      <= '0;
         header_length_ff    <= '0;
         header_seq_ff       <= '0;
         body_phase_ff       <= PH_IDLE;
         field_shift_ff      <= '0;
         field_bytes_left_ff <= '0;
         entries_left_ff     <= '0;
         body_overrun_ff     <= 1'b0;
         cap_port_ff         <= '0;
         cap_count_ff        <= '0;
         cap_size_ff         <= '0;
      end else begin
         byte_index_ff       <= byte_index_in;
         magic_ok_ff         <= magic_ok_in;
         version_ok_ff       <= version_ok_in;
         header_type_ff      <= header_type_in;
         header_length_ff    <= header_length_in;
         header_seq_ff       <= header_seq_in;
         body_phase_ff       <= body_phase_in;
         field_shift_ff      <= field_shift_in;
         field_bytes_left_ff <= field_bytes_left_in;
         entries_left_ff     <= entries_left_in;
         body_overrun_ff     <= body_overrun_in;
         cap_port_ff         <= cap_port_in;
         cap_count_ff        <= cap_count_in;
         cap_size_ff         <= cap_size_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff      <= rsp_status_in;
      rsp_msg_type_ff    <= rsp_msg_type_in;
      rsp_seq_number_ff  <= rsp_seq_number_in;
      rsp_body_length_ff <= rsp_body_length_in;
      rsp_peer_port_ff   <= rsp_peer_port_in;
      rsp_entry_count_ff <= rsp_entry_count_in;
      rsp_file_size_ff   <= rsp_file_size_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_msg_type    = rsp_msg_type_ff;
   assign rsp_seq_number  = rsp_seq_number_ff;
   assign rsp_body_length = rsp_body_length_ff;
   assign rsp_peer_port   = rsp_peer_port_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_file_size   = rsp_file_size_ff;

endmodule
